>>> rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Word formats, job codes and datapath widths used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COEF_W      = 32;
  localparam int TOL_W       = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // front pipeline depth, used by the queue to hold back the producer
  localparam int FRONT_LAT   = 4;
  localparam int QUEUE_DEPTH = 8;

  // datapath widths
  localparam int JNUM_W  = 34;  // -b, -c, a, b, 2a
  localparam int NUM_W   = 35;  // -b +/- sqrt(d)
  localparam int DEN_W   = 34;
  localparam int E_W     = 63;  // d/4, kept unsigned; negative values are queued truncated
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int REM_W   = 35;
  localparam int SQ_STAGES = RAD_W / 2;
  localparam int QUOT_W  = 33;
  localparam int DIV_LAT = QUOT_W + 2;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  // job kinds decided by the front
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_ALL   = 3'd1;
  localparam logic [2:0] KIND_DIV   = 3'd2;
  localparam logic [2:0] KIND_ZEROC = 3'd3;
  localparam logic [2:0] KIND_GEN   = 3'd4;

  localparam logic [QUOT_W-1:0] QMAG_NEG = 33'h080000000;
  localparam logic [QUOT_W-1:0] QMAG_POS = 33'h07FFFFFFF;
  localparam logic [COEF_W-1:0] ROOT_MIN = 32'h80000000;
  localparam logic [COEF_W-1:0] ROOT_MAX = 32'h7FFFFFFF;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]               root_count;
    logic signed [COEF_W-1:0] root_first;
    logic signed [COEF_W-1:0] root_second;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [1:0]               rem;
    logic signed [JNUM_W-1:0] num;
    logic signed [DEN_W-1:0]  den;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [E_W-1:0] e;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: coefficient front end
// Zero tests, discriminant products and case selection; emits one job a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  qrs_pkg::in_t                  in_data,
  input  logic [qrs_pkg::TOL_W-1:0]     tol,
  output logic                          job_valid,
  output qrs_pkg::job_t                 job
);

  localparam int CW = qrs_pkg::COEF_W;
  localparam int JW = qrs_pkg::JNUM_W;
  localparam int TW = 2 * CW + 2;

  // stage 1
  logic                 v1_r;
  logic signed [CW-1:0] a1_r, b1_r, c1_r;
  logic                 az1_r, bz1_r, cz1_r;
  logic [CW-1:0]        mag_a, mag_b, mag_c;
  logic [CW-1:0]        tol_ext;

  // stage 2
  logic                     v2_r;
  logic signed [CW-1:0]     a2_r, b2_r, c2_r;
  logic                     az2_r, bz2_r, cz2_r;
  logic signed [2*CW-1:0]   bb2_nxt, ac2_nxt, bb2_r, ac2_r;

  // stage 3
  logic                     v3_r;
  logic signed [CW-1:0]     a3_r, b3_r, c3_r;
  logic                     az3_r, bz3_r, cz3_r;
  logic signed [2*CW-1:0]   e3_nxt, e3_r;
  logic [1:0]               rem3_r;

  // stage 4
  logic                     v4_r;
  qrs_pkg::job_t            job_nxt, job_r;
  logic [TW-1:0]            thr;
  logic                     dzero;
  logic signed [JW-1:0]     neg_b, neg_c, den_a, den_b, den_2a;

  assign tol_ext = CW'(tol);
  assign mag_a   = in_data.coef_a[CW-1] ? -in_data.coef_a : in_data.coef_a;
  assign mag_b   = in_data.coef_b[CW-1] ? -in_data.coef_b : in_data.coef_b;
  assign mag_c   = in_data.coef_c[CW-1] ? -in_data.coef_c : in_data.coef_c;

  assign bb2_nxt = b1_r * b1_r;
  assign ac2_nxt = a1_r * c1_r;

  // e = floor(b*b/4) - a*c, d = 4e + rem
  assign e3_nxt = $signed({2'b00, bb2_r[2*CW-1:2]}) - ac2_r;

  assign thr    = TW'(tol) << FRAC_BITS;
  assign dzero  = {e3_r, rem3_r} <= thr;
  assign neg_b  = -JW'(b3_r);
  assign neg_c  = -JW'(c3_r);
  assign den_a  = JW'(a3_r);
  assign den_b  = JW'(b3_r);
  assign den_2a = JW'(a3_r) <<< 1;

  always_comb begin
    job_nxt          = '0;
    job_nxt.e        = e3_r[qrs_pkg::E_W-1:0];
    job_nxt.side.rem = rem3_r;
    job_nxt.side.den = den_2a;
    job_nxt.side.num = neg_b;
    priority if (az3_r) begin
      if (bz3_r) begin
        job_nxt.side.kind = cz3_r ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
        job_nxt.side.num  = '0;
      end else begin
        job_nxt.side.kind = qrs_pkg::KIND_DIV;
        job_nxt.side.num  = neg_c;
        job_nxt.side.den  = den_b;
      end
    end else if (e3_r[2*CW-1]) begin
      job_nxt.side.kind = qrs_pkg::KIND_NONE;
      job_nxt.side.num  = '0;
    end else if (dzero) begin
      job_nxt.side.kind = qrs_pkg::KIND_DIV;
    end else if (cz3_r) begin
      job_nxt.side.kind = qrs_pkg::KIND_ZEROC;
      job_nxt.side.den  = den_a;
    end else begin
      job_nxt.side.kind = qrs_pkg::KIND_GEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r  <= in_data.coef_a;
    b1_r  <= in_data.coef_b;
    c1_r  <= in_data.coef_c;
    az1_r <= mag_a <= tol_ext;
    bz1_r <= mag_b <= tol_ext;
    cz1_r <= mag_c <= tol_ext;

    a2_r  <= a1_r;
    b2_r  <= b1_r;
    c2_r  <= c1_r;
    az2_r <= az1_r;
    bz2_r <= bz1_r;
    cz2_r <= cz1_r;
    bb2_r <= bb2_nxt;
    ac2_r <= ac2_nxt;

    a3_r   <= a2_r;
    b3_r   <= b2_r;
    c3_r   <= c2_r;
    az3_r  <= az2_r;
    bz3_r  <= bz2_r;
    cz3_r  <= cz2_r;
    e3_r   <= e3_nxt;
    rem3_r <= bb2_r[1:0];

    job_r <= job_nxt;
  end

  assign job_valid = v4_r;
  assign job       = job_r;

endmodule

`default_nettype wire

>>> rtl/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo: job queue between front and back
// Small circular buffer; raises busy early enough to absorb the front pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_fifo #(
  parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qrs_pkg::job_t push_data,
  output logic          out_valid,
  output qrs_pkg::job_t out_data,
  output logic          busy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qrs_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          pop;
  logic          valid_r;
  qrs_pkg::job_t data_r;

  // the back end never stalls, so any queued word leaves at once
  assign pop = count_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
      valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
    if (pop) begin
      data_r <= mem[rd_ptr_r];
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign busy      = count_r >= CW'(DEPTH - qrs_pkg::FRONT_LAT);

endmodule

`default_nettype wire

>>> rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One root bit per stage; returns floor root and remainder with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [qrs_pkg::RAD_W-1:0]     in_rad,
  input  qrs_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [qrs_pkg::ROOT_W-1:0]    out_root,
  output logic [qrs_pkg::REM_W-1:0]     out_rem,
  output qrs_pkg::side_t                out_side
);

  localparam int N  = qrs_pkg::SQ_STAGES;
  localparam int DW = qrs_pkg::RAD_W;
  localparam int SW = qrs_pkg::ROOT_W;
  localparam int RW = qrs_pkg::REM_W;

  logic [N-1:0]   v_r;
  logic [DW-1:0]  rad_r  [N];
  logic [RW-1:0]  rem_r  [N];
  logic [SW-1:0]  root_r [N];
  qrs_pkg::side_t side_r [N];

  logic [DW-1:0]  rad_nxt  [N];
  logic [RW-1:0]  rem_nxt  [N];
  logic [SW-1:0]  root_nxt [N];
  logic [DW-1:0]  src_rad  [N];
  logic [RW-1:0]  src_rem  [N];
  logic [SW-1:0]  src_root [N];

  always_comb begin
    src_rad[0]  = in_rad;
    src_rem[0]  = '0;
    src_root[0] = '0;
    for (int k = 1; k < N; k++) begin
      src_rad[k]  = rad_r[k-1];
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
    end
  end

  always_comb begin
    logic [RW-1:0] cur;
    logic [RW-1:0] trial;
    for (int k = 0; k < N; k++) begin
      cur   = {src_rem[k][RW-3:0], src_rad[k][DW-1 -: 2]};
      trial = RW'({src_root[k], 2'b01});
      rad_nxt[k] = {src_rad[k][DW-3:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt[k]  = cur - trial;
        root_nxt[k] = {src_root[k][SW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cur;
        root_nxt[k] = {src_root[k][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int k = 1; k < N; k++) begin
      side_r[k] <= side_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_rem   = rem_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

`default_nettype wire

>>> rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: pipelined fixed-point divider
// Restoring division, one quotient bit per stage, truncation and clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [qrs_pkg::NUM_W-1:0]    in_num,
  input  logic signed [qrs_pkg::DEN_W-1:0]    in_den,
  output logic                                out_valid,
  output logic signed [qrs_pkg::COEF_W-1:0]   out_quot,
  output logic                                out_sat
);

  localparam int QW = qrs_pkg::QUOT_W;
  localparam int NW = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DEN_W - 1;
  localparam int MW = NW - 1 + FRAC_BITS;
  localparam int HW = MW - QW;
  localparam int RW = DW + 1;
  localparam int CW = qrs_pkg::COEF_W;

  logic [NW-1:0]  num_neg;
  logic [DW:0]    den_neg;
  logic [MW-1:0]  mn;
  logic [DW-1:0]  md;
  logic [HW-1:0]  hi;

  logic [QW:0]    v_r;
  logic [RW-1:0]  rr_r  [QW+1];
  logic [QW-1:0]  lo_r  [QW+1];
  logic [QW-1:0]  q_r   [QW+1];
  logic [DW-1:0]  md_r  [QW+1];
  logic           neg_r [QW+1];
  logic           ovf_r [QW+1];

  logic [RW-1:0]  rr_nxt [QW+1];
  logic [QW-1:0]  lo_nxt [QW+1];
  logic [QW-1:0]  q_nxt  [QW+1];

  logic           vo_r;
  logic [CW-1:0]  quot_r;
  logic           sat_r;
  logic [QW-1:0]  q_fin;
  logic [QW-1:0]  q_neg;
  logic           big;

  assign num_neg = -in_num;
  assign den_neg = -in_den;
  assign mn = MW'(in_num[NW-1] ? num_neg[NW-2:0] : in_num[NW-2:0]) << FRAC_BITS;
  assign md = in_den[DW] ? den_neg[DW-1:0] : in_den[DW-1:0];
  assign hi = mn[MW-1:QW];

  always_comb begin
    logic [RW-1:0] cur;
    rr_nxt[0] = RW'(hi);
    lo_nxt[0] = mn[QW-1:0];
    q_nxt[0]  = '0;
    for (int k = 0; k < QW; k++) begin
      cur = {rr_r[k][RW-2:0], lo_r[k][QW-1]};
      lo_nxt[k+1] = {lo_r[k][QW-2:0], 1'b0};
      if (cur >= RW'(md_r[k])) begin
        rr_nxt[k+1] = cur - RW'(md_r[k]);
        q_nxt[k+1]  = {q_r[k][QW-2:0], 1'b1};
      end else begin
        rr_nxt[k+1] = cur;
        q_nxt[k+1]  = {q_r[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else begin
      v_r  <= {v_r[QW-1:0], in_valid};
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    md_r[0]  <= md;
    neg_r[0] <= in_num[NW-1] != in_den[DW];
    // quotient would not fit in the kept bits
    ovf_r[0] <= RW'(hi) >= RW'(md);
    for (int k = 1; k <= QW; k++) begin
      md_r[k]  <= md_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
    for (int k = 0; k <= QW; k++) begin
      rr_r[k] <= rr_nxt[k];
      lo_r[k] <= lo_nxt[k];
      q_r[k]  <= q_nxt[k];
    end
  end

  assign q_fin = q_r[QW];
  assign q_neg = -q_fin;
  assign big   = ovf_r[QW] ||
                 (neg_r[QW] ? (q_fin > qrs_pkg::QMAG_NEG) : (q_fin > qrs_pkg::QMAG_POS));

  always_ff @(posedge clk) begin
    sat_r <= big;
    if (neg_r[QW]) begin
      quot_r <= big ? qrs_pkg::ROOT_MIN : q_neg[CW-1:0];
    end else begin
      quot_r <= big ? qrs_pkg::ROOT_MAX : q_fin[CW-1:0];
    end
  end

  assign out_valid = vo_r;
  assign out_quot  = quot_r;
  assign out_sat   = sat_r;

endmodule

`default_nettype wire

>>> rtl/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back: root evaluation back end
// Square root, root numerators, two dividers and result formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_back #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  qrs_pkg::job_t job,
  output logic          out_strobe,
  output qrs_pkg::out_t out_data
);

  localparam int NW = qrs_pkg::NUM_W;
  localparam int SW = qrs_pkg::ROOT_W;
  localparam int RW = qrs_pkg::REM_W;
  localparam int CW = qrs_pkg::COEF_W;
  localparam int L  = qrs_pkg::DIV_LAT;

  logic                  sq_v;
  logic [SW-1:0]         sq_root;
  logic [RW-1:0]         sq_rem;
  qrs_pkg::side_t        sq_side;

  logic                  up;
  logic [SW:0]           sq;
  logic signed [NW-1:0]  sq_s, num_ext;

  logic                  fx_v_r;
  qrs_pkg::side_t        fx_side_r;
  logic signed [NW-1:0]  num1_r, num2_r;

  logic                  d1_v, d2_v;
  logic signed [CW-1:0]  q1, q2;
  logic                  s1, s2;

  qrs_pkg::side_t        side_dl_r [L];

  logic                  strobe_r;
  qrs_pkg::out_t         out_r, out_nxt;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (job_valid),
    .in_rad    ({1'b0, job.e}),
    .in_side   (job.side),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_rem   (sq_rem),
    .out_side  (sq_side)
  );

  // round 2*sqrt(e) to the floor root of the full discriminant
  assign up      = (sq_side.rem != 2'd0) ? (sq_rem >= RW'(sq_root)) : (sq_rem > RW'(sq_root));
  assign sq      = {sq_root, 1'b0} + (SW+1)'(up);
  assign sq_s    = $signed(NW'(sq));
  assign num_ext = NW'(sq_side.num);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_v_r <= 1'b0;
    end else begin
      fx_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    fx_side_r <= sq_side;
    if (sq_side.kind == qrs_pkg::KIND_GEN) begin
      num1_r <= num_ext + sq_s;
      num2_r <= num_ext - sq_s;
    end else begin
      num1_r <= num_ext;
      num2_r <= '0;
    end
  end

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fx_v_r),
    .in_num    (num1_r),
    .in_den    (fx_side_r.den),
    .out_valid (d1_v),
    .out_quot  (q1),
    .out_sat   (s1)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fx_v_r),
    .in_num    (num2_r),
    .in_den    (fx_side_r.den),
    .out_valid (d2_v),
    .out_quot  (q2),
    .out_sat   (s2)
  );

  always_ff @(posedge clk) begin
    side_dl_r[0] <= fx_side_r;
    for (int k = 1; k < L; k++) begin
      side_dl_r[k] <= side_dl_r[k-1];
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (side_dl_r[L-1].kind)
      qrs_pkg::KIND_ALL: begin
        out_nxt.root_count = qrs_pkg::CNT_ALL;
      end
      qrs_pkg::KIND_DIV: begin
        out_nxt.root_count = qrs_pkg::CNT_ONE;
        out_nxt.root_first = q1;
        out_nxt.saturated  = s1;
      end
      qrs_pkg::KIND_ZEROC: begin
        // roots are 0 and -b/a, larger first
        out_nxt.root_count = qrs_pkg::CNT_TWO;
        out_nxt.saturated  = s1;
        if (q1 > 0) begin
          out_nxt.root_first = q1;
        end else begin
          out_nxt.root_second = q1;
        end
      end
      qrs_pkg::KIND_GEN: begin
        out_nxt.root_count  = qrs_pkg::CNT_TWO;
        out_nxt.root_first  = q1;
        out_nxt.root_second = q2;
        out_nxt.saturated   = s1 | s2;
      end
      default: begin
        out_nxt.root_count = qrs_pkg::CNT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= d1_v & d2_v;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

`default_nettype wire

>>> rtl/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: real roots of a*x^2 + b*x + c = 0, Q16.16
// Front end classifies coefficient words, a queue decouples it from the
// square-root and divider back end.
//
//   channel  ports                      direction  transfer
//   input    start, busy, in_data       in         start && !busy
//   result   out_strobe, out_data       out        one cycle strobe
//   config   cfg_we, cfg_wdata          in         cfg_we
//
// one word accepted per cycle while busy is low; each result passes through
// the 32-stage square root and the dividers in series
// synchronous active-low reset clears all valid flags, tolerance resets to 1
// busy rises once the queue holds DEPTH - FRONT_LAT jobs, which a free-running back end avoids
// out_strobe cannot be held off; each result is shown for a single cycle
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_core #(
  parameter int FRAC_BITS   = qrs_pkg::FRAC_BITS,
  parameter int QUEUE_DEPTH = qrs_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  qrs_pkg::in_t              in_data,
  output logic                      out_strobe,
  output qrs_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [qrs_pkg::TOL_W-1:0] cfg_wdata
);

  logic [qrs_pkg::TOL_W-1:0] tol_r;
  logic                      accept;
  logic                      job_valid;
  qrs_pkg::job_t             job;
  logic                      q_valid;
  qrs_pkg::job_t             q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrs_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign accept = start && !busy;

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .tol       (tol_r),
    .job_valid (job_valid),
    .job       (job)
  );

  qrs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job),
    .out_valid (q_valid),
    .out_data  (q_data),
    .busy      (busy)
  );

  qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job        (q_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // no-root and every-x results carry no roots and no saturation
  a_empty_roots: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_data.root_count == qrs_pkg::CNT_NONE ||
                   out_data.root_count == qrs_pkg::CNT_ALL)
    |-> out_data.root_first == '0 && out_data.root_second == '0 && !out_data.saturated)
    else $error("root word set on a rootless result");

  a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.root_count == qrs_pkg::CNT_ONE |-> out_data.root_second == '0)
    else $error("second root set on a single-root result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire
